// ===== rtl/olse_pkg.sv =====
// shared types and constants for the online log-sum-exp reducer
package olse_pkg;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_EXP_SCALE,
        OP_EXP_TERM,
        OP_LANE_UPD,
        OP_GMAX_INIT,
        OP_GMAX_STEP,
        OP_MEXP,
        OP_MACC,
        OP_CLAMP,
        OP_NORM_STEP,
        OP_LOG1,
        OP_LOG2,
        OP_LOG3,
        OP_LN,
        OP_EMIT
    } t_op;

    // status flags from datapath to controller
    typedef struct packed {
        logic exp_done;
        logic lane_more;
        logic idx_last;
        logic norm_done;
        logic last;
        logic any_seen;
        logic out_busy;
    } t_dp_status;

    // exponential constants, q16
    localparam logic [16:0] EXP_LOG2E = 17'd94548;
    localparam logic [17:0] EXP_C3    = 18'd5112;
    localparam logic [17:0] EXP_C2    = 18'd14824;
    localparam logic [17:0] EXP_C1    = 18'd45600;
    localparam logic [17:0] ONE_Q16   = 18'd65536;

    // log2 polynomial constants, q16
    localparam logic [16:0] LOG_C2 = 17'd10434;
    localparam logic [16:0] LOG_C1 = 17'd38147;
    localparam logic [16:0] LOG_C0 = 17'd93249;
    localparam logic [16:0] LN2_Q16 = 17'd45426;

    // result bounds
    localparam logic [23:0] OUT_MIN = 24'h800000;
    localparam logic [23:0] OUT_MAX = 24'h7fffff;

endpackage

// ===== rtl/olse_exp.sv =====
// iterative exp(-d) unit: q.10 difference in, q16 result out
module olse_exp
    import olse_pkg::*;
#(
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_d,
    output logic          o_done,
    output logic [16:0]   o_res
);

    localparam int ZW = DW + 20;
    localparam int KW = ZW - 26;

    logic [ZW-1:0] r_z;
    logic [17:0]   r_p;
    logic [1:0]    r_step;
    logic          r_busy;
    logic          r_done;
    logic [16:0]   r_res;

    logic [16:0]   g;
    logic [17:0]   mul_a;
    logic [17:0]   add_c;
    logic [34:0]   prod;
    logic [17:0]   n_p;
    logic [KW-1:0] k;
    logic [16:0]   n_res;

    // fraction complement and horner step
    always_comb begin
        g     = 17'(ONE_Q16) - {1'b0, r_z[25:10]};
        mul_a = (r_step == 2'd0) ? EXP_C3 : r_p;
        case (r_step)
            2'd0:    add_c = EXP_C2;
            2'd1:    add_c = EXP_C1;
            default: add_c = ONE_Q16;
        endcase
        prod = 35'(mul_a) * 35'(g);
        n_p  = 18'((prod >> 16) + 35'(add_c));
        k    = r_z[ZW-1:26];
        if (k >= 18) begin
            n_res = 17'd0;
        end else begin
            n_res = 17'(r_p >> (5'(k) + 5'd1));
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_z <= ZW'(i_d) * ZW'(EXP_LOG2E);
        end
        if (r_busy && r_step != 2'd3) begin
            r_p <= n_p;
        end
        if (r_busy && r_step == 2'd3) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/olse_dp.sv =====
// datapath: lane state, shared exp unit, merge, logarithm and result register
module olse_dp
    import olse_pkg::*;
#(
    parameter int LANES        = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_LOG2   = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_op                         i_op,
    output t_dp_status                  o_st,
    input  logic [LANES*SAMPLE_WIDTH-1:0] i_lanes,
    input  logic [3:0]                  i_cnt,
    input  logic                        i_last,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [23:0]                 o_lse,
    output logic                        o_empty,
    output logic                        o_sat
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int IW   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW   = $clog2(LANES + 1);
    localparam int SUMW = COUNT_LOG2 + 16;
    localparam int TW   = SUMW + $clog2(LANES) + 1;
    localparam int PW   = $clog2(TW);
    localparam int L2W  = PW + 17;
    localparam int LNW  = L2W + 17 + 1 - 22;
    localparam int RW0  = ((SW > LNW) ? SW : LNW) + 2;
    localparam int XW   = (RW0 > 25) ? RW0 : 25;
    localparam int MW   = SUMW + 17;

    logic signed [SW-1:0]   r_x [LANES];
    logic signed [SW-1:0]   r_max [LANES];
    logic [SUMW-1:0]        r_sum [LANES];
    logic [CW-1:0]          r_cnt;
    logic                   r_last;
    logic [CW-1:0]          r_idx;
    logic                   r_any;
    logic                   r_ovf;
    logic signed [SW-1:0]   r_nm;
    logic [16:0]            r_scale;
    logic signed [SW-1:0]   r_gm;
    logic [TW-1:0]          r_tot;
    logic [PW-1:0]          r_pos;
    logic [16:0]            r_q;
    logic [L2W-1:0]         r_l2;
    logic [LNW-1:0]         r_ln;
    logic                   r_out_valid;
    logic [23:0]            r_lse;
    logic                   r_empty;
    logic                   r_sat;

    logic [IW-1:0]          li;
    logic signed [SW-1:0]   cur_x;
    logic signed [SW-1:0]   cur_max;
    logic [SUMW-1:0]        cur_sum;
    logic signed [SW-1:0]   nm;
    logic signed [SW:0]     diff;
    logic                   exp_start;
    logic                   exp_done;
    logic [16:0]            exp_res;
    logic [MW-1:0]          prod;
    logic [SUMW:0]          s_new;
    logic [15:0]            u;
    logic [29:0]            p_log1;
    logic [33:0]            p_log2;
    logic [L2W+16:0]        p_ln;
    logic signed [XW-1:0]   r_wide;
    logic [23:0]            lse_sat;
    logic [CW-1:0]          idx_next;
    logic [CW-1:0]          cnt_sat;

    assign li      = r_idx[IW-1:0];
    assign cur_x   = r_x[li];
    assign cur_max = r_max[li];
    assign cur_sum = r_sum[li];
    assign nm      = (cur_x > cur_max) ? cur_x : cur_max;
    assign idx_next = (r_idx == CW'(LANES - 1)) ? '0 : r_idx + 1'b1;
    assign cnt_sat = ({1'b0, i_cnt} > 5'(LANES)) ? CW'(LANES) : CW'(i_cnt);

    // exp operand select
    always_comb begin
        exp_start = 1'b0;
        diff      = '0;
        case (i_op)
            OP_EXP_SCALE: begin
                exp_start = 1'b1;
                diff      = (SW+1)'(nm) - (SW+1)'(cur_max);
            end
            OP_EXP_TERM: begin
                exp_start = 1'b1;
                diff      = (SW+1)'(r_nm) - (SW+1)'(cur_x);
            end
            OP_MEXP: begin
                exp_start = 1'b1;
                diff      = (SW+1)'(r_gm) - (SW+1)'(cur_max);
            end
            default: begin
                exp_start = 1'b0;
                diff      = '0;
            end
        endcase
    end

    olse_exp #(
        .DW(SW)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_d     (diff[SW-1:0]),
        .o_done  (exp_done),
        .o_res   (exp_res)
    );

    // shared lane multiplier: rescale or merge weight
    always_comb begin
        prod  = MW'(cur_sum) * MW'((i_op == OP_MACC) ? exp_res : r_scale);
        s_new = (SUMW+1)'(prod >> 16) + (SUMW+1)'(exp_res);
    end

    // logarithm terms
    always_comb begin
        u      = r_tot[TW-2 -: 16];
        p_log1 = 30'(LOG_C2) * 30'(u);
        p_log2 = 34'(r_q) * 34'(u);
        p_ln   = (L2W+17)'(r_l2) * (L2W+17)'(LN2_Q16) + (L2W+17)'(1 << 21);
        r_wide = XW'(r_gm) + $signed(XW'(r_ln));
        if (r_wide > $signed(XW'(OUT_MAX))) begin
            lse_sat = OUT_MAX;
        end else if (r_wide < -$signed(XW'(OUT_MIN))) begin
            lse_sat = OUT_MIN;
        end else begin
            lse_sat = r_wide[23:0];
        end
    end

    // control state: indexes, flags, output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_any       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_tot       <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_max[i] <= {1'b1, {(SW-1){1'b0}}};
                r_sum[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_CAPTURE: begin
                    r_idx <= '0;
                end
                OP_LANE_UPD: begin
                    r_sum[li] <= s_new[SUMW] ? {SUMW{1'b1}} : s_new[SUMW-1:0];
                    r_max[li] <= r_nm;
                    r_ovf     <= r_ovf | s_new[SUMW];
                    r_any     <= 1'b1;
                    r_idx     <= r_idx + 1'b1;
                end
                OP_GMAX_INIT: begin
                    r_idx <= '0;
                end
                OP_GMAX_STEP: begin
                    r_idx <= idx_next;
                end
                OP_MACC: begin
                    r_tot <= r_tot + TW'(prod >> 16);
                    r_idx <= idx_next;
                end
                OP_CLAMP: begin
                    if (r_tot < TW'(ONE_Q16)) begin
                        r_tot <= TW'(ONE_Q16);
                    end
                end
                OP_NORM_STEP: begin
                    r_tot <= r_tot << 1;
                end
                OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_any       <= 1'b0;
                    r_ovf       <= 1'b0;
                    r_tot       <= '0;
                    r_idx       <= '0;
                    for (int i = 0; i < LANES; i++) begin
                        r_max[i] <= {1'b1, {(SW-1){1'b0}}};
                        r_sum[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_CAPTURE: begin
                for (int i = 0; i < LANES; i++) begin
                    r_x[i] <= i_lanes[i*SW +: SW];
                end
                r_cnt  <= cnt_sat;
                r_last <= i_last;
            end
            OP_EXP_SCALE: begin
                r_nm <= nm;
            end
            OP_EXP_TERM: begin
                r_scale <= exp_res;
            end
            OP_GMAX_INIT: begin
                r_gm <= {1'b1, {(SW-1){1'b0}}};
            end
            OP_GMAX_STEP: begin
                if (cur_max > r_gm) begin
                    r_gm <= cur_max;
                end
            end
            OP_CLAMP: begin
                r_pos <= PW'(TW - 1);
            end
            OP_NORM_STEP: begin
                r_pos <= r_pos - 1'b1;
            end
            OP_LOG1: begin
                r_q <= LOG_C1 - 17'(p_log1 >> 16);
            end
            OP_LOG2: begin
                r_q <= LOG_C0 - 17'(p_log2 >> 16);
            end
            OP_LOG3: begin
                r_l2 <= {PW'(r_pos - PW'(16)), 16'd0} + L2W'(p_log2 >> 16);
            end
            OP_LN: begin
                r_ln <= LNW'(p_ln >> 22);
            end
            OP_EMIT: begin
                r_lse   <= r_any ? lse_sat : OUT_MIN;
                r_empty <= !r_any;
                r_sat   <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    // status to controller
    always_comb begin
        o_st.exp_done  = exp_done;
        o_st.lane_more = (r_idx < r_cnt);
        o_st.idx_last  = (r_idx == CW'(LANES - 1));
        o_st.norm_done = r_tot[TW-1];
        o_st.last      = r_last;
        o_st.any_seen  = r_any;
        o_st.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_lse       = r_lse;
    assign o_empty     = r_empty;
    assign o_sat       = r_sat;

endmodule

// ===== rtl/olse_ctrl.sv =====
// controller state machine sequencing lane updates, merge and logarithm
module olse_ctrl
    import olse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_op        o_op
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_LANE   = 13'b0000000000010,
        ST_EXPS   = 13'b0000000000100,
        ST_EXPT   = 13'b0000000001000,
        ST_GMAX   = 13'b0000000010000,
        ST_MSTART = 13'b0000000100000,
        ST_MWAIT  = 13'b0000001000000,
        ST_CLAMP  = 13'b0000010000000,
        ST_NORM   = 13'b0000100000000,
        ST_LOG2   = 13'b0001000000000,
        ST_LOG3   = 13'b0010000000000,
        ST_LN     = 13'b0100000000000,
        ST_EMIT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and operation
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_CAPTURE;
                    n_state = ST_LANE;
                end
            end
            ST_LANE: begin
                if (i_st.lane_more) begin
                    o_op    = OP_EXP_SCALE;
                    n_state = ST_EXPS;
                end else if (!i_st.last) begin
                    n_state = ST_IDLE;
                end else if (!i_st.any_seen) begin
                    n_state = ST_EMIT;
                end else begin
                    o_op    = OP_GMAX_INIT;
                    n_state = ST_GMAX;
                end
            end
            ST_EXPS: begin
                if (i_st.exp_done) begin
                    o_op    = OP_EXP_TERM;
                    n_state = ST_EXPT;
                end
            end
            ST_EXPT: begin
                if (i_st.exp_done) begin
                    o_op    = OP_LANE_UPD;
                    n_state = ST_LANE;
                end
            end
            ST_GMAX: begin
                o_op = OP_GMAX_STEP;
                if (i_st.idx_last) begin
                    n_state = ST_MSTART;
                end
            end
            ST_MSTART: begin
                o_op    = OP_MEXP;
                n_state = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_st.exp_done) begin
                    o_op    = OP_MACC;
                    n_state = i_st.idx_last ? ST_CLAMP : ST_MSTART;
                end
            end
            ST_CLAMP: begin
                o_op    = OP_CLAMP;
                n_state = ST_NORM;
            end
            ST_NORM: begin
                if (i_st.norm_done) begin
                    o_op    = OP_LOG1;
                    n_state = ST_LOG2;
                end else begin
                    o_op = OP_NORM_STEP;
                end
            end
            ST_LOG2: begin
                o_op    = OP_LOG2;
                n_state = ST_LOG3;
            end
            ST_LOG3: begin
                o_op    = OP_LOG3;
                n_state = ST_LN;
            end
            ST_LN: begin
                o_op    = OP_LN;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_st.out_busy) begin
                    o_op    = OP_EMIT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/online_logsumexp_reduce_top.sv =====
// top level of the streaming online log-sum-exp reducer
//
// Takes groups of LANES signed q.10 samples and, on the group marked by tlast,
// returns ln(sum(exp(x))) in signed q13.10 with an empty-vector flag and a
// sum-saturation flag, then clears its lane state. One item at a time: each
// valid lane of an item runs through the one shared iterative exponential
// unit twice (rescale and new term) before the next item is taken. A last
// group adds the merge: a scan for the global maximum, an exponential weight
// per lane, a clamp, normalization at one bit per cycle with the first
// logarithm step, and the rest of the logarithm and the output.
// The result sits in an output register, so the next item is taken while it
// waits; only a second result waits for the first to be taken.
module online_logsumexp_reduce_top
    import olse_pkg::*;
#(
    parameter int LANES        = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_LOG2   = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // lane0_value .. laneN_value, valid_lanes, zero fill
    input  logic [((LANES*SAMPLE_WIDTH+4+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                   s_axis_tlast,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // log_sum_exp
    output logic [23:0]                            m_axis_tdata,
    // empty_vector, sum_saturated
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready
);

    localparam int LBITS = LANES * SAMPLE_WIDTH;

    t_op        op;
    t_dp_status st;
    logic       empty;
    logic       sat;

    olse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_op       (op)
    );

    olse_dp #(
        .LANES        (LANES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_LOG2   (COUNT_LOG2)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_st        (st),
        .i_lanes     (s_axis_tdata[LBITS-1:0]),
        .i_cnt       (s_axis_tdata[LBITS +: 4]),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_lse       (m_axis_tdata),
        .o_empty     (empty),
        .o_sat       (sat)
    );

    assign m_axis_tuser = {sat, empty};

    // output register is empty after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty vector always reports the floor value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == OUT_MIN))
        else $error("empty vector result not at floor");

    // the controller never accepts items on back-to-back cycles
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted on back-to-back cycles");

endmodule

// ===== tb/sv/online_logsumexp_reduce_top_tb.sv =====
// testbench for the streaming online log-sum-exp reducer
module online_logsumexp_reduce_top_tb
    import olse_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES = 8;
    localparam int SW = 16;
    localparam int CL2 = 20;
    localparam int DW = ((LANES*SW+4+7)/8)*8;
    localparam longint unsigned SUM_CAP = (64'd1 << (CL2+16)) - 1;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [23:0] lse;
        logic        empty;
        logic        sat;
    } t_result;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tlast = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [23:0]   m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tvalid;
    logic          m_tready = 0;

    online_logsumexp_reduce_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_tdata), .s_axis_tlast(s_tlast),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    longint          lmax [LANES];
    longint unsigned lsum [LANES];
    bit              seen_any, seen_ovf;
    t_result         pending_q[$];
    int              fails = 0;
    longint          cycles = 0;
    int              idle_pct = 32;
    bit              hold_rx = 0;

    function automatic longint unsigned exp_neg_q16(longint unsigned d);
        longint unsigned z, k, g, p;
        z = d * 94548;
        k = z >> 26;
        g = 65536 - ((z >> 10) & 16'hffff);
        p = ((5112 * g) >> 16) + 14824;
        p = ((p * g) >> 16) + 45600;
        p = ((p * g) >> 16) + 65536;
        if (k + 1 >= 64) return 0;
        return p >> (k + 1);
    endfunction

    function automatic longint unsigned ln_q10(longint unsigned t);
        int unsigned e;
        longint unsigned m, u, q, l2;
        e = 0;
        while (e < 63 && (t >> (e + 1)) != 0) e++;
        m = (e >= 16) ? (t >> (e - 16)) : (t << (16 - e));
        u = m - 65536;
        q = 38147 - ((10434 * u) >> 16);
        q = 93249 - ((q * u) >> 16);
        l2 = longint'(e - 16) * 65536 + ((q * u) >> 16);
        return (l2 * 45426 + (64'd1 << 21)) >> 22;
    endfunction

    function automatic void clear_lanes();
        for (int i = 0; i < LANES; i++) begin
            lmax[i] = -32768;
            lsum[i] = 0;
        end
        seen_any = 0;
        seen_ovf = 0;
    endfunction

    // absorb one group, queue a result on the last group
    function automatic void absorb_group(logic [15:0] v [LANES], int cnt, bit last);
        longint x, nm, gm, r;
        longint unsigned s, total;
        t_result res;
        if (cnt > LANES) cnt = LANES;
        for (int i = 0; i < cnt; i++) begin
            x = longint'($signed(v[i]));
            nm = (x > lmax[i]) ? x : lmax[i];
            s = ((lsum[i] * exp_neg_q16(nm - lmax[i])) >> 16) + exp_neg_q16(nm - x);
            if (s > SUM_CAP) begin
                s = SUM_CAP;
                seen_ovf = 1;
            end
            lsum[i] = s;
            lmax[i] = nm;
            seen_any = 1;
        end
        if (!last) return;
        res.sat = seen_ovf;
        if (!seen_any) begin
            res.lse = OUT_MIN;
            res.empty = 1;
        end else begin
            gm = lmax[0];
            for (int i = 1; i < LANES; i++) if (lmax[i] > gm) gm = lmax[i];
            total = 0;
            for (int i = 0; i < LANES; i++)
                total += (lsum[i] * exp_neg_q16(gm - lmax[i])) >> 16;
            if (total < 65536) total = 65536;
            r = gm + longint'(ln_q10(total));
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            res.lse = r[23:0];
            res.empty = 0;
        end
        pending_q.push_back(res);
        clear_lanes();
    endfunction

    // send one group and predict it on acceptance
    task automatic send_group(logic [15:0] v [LANES], int cnt, bit last);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < LANES; i++) d[i*SW +: SW] = v[i];
        d[LANES*SW +: 4] = cnt[3:0];
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tdata <= d;
        s_tlast <= last;
        s_tvalid <= 1;
        do @(posedge i_clk); while (!s_tready);
        absorb_group(v, cnt, last);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 255) - 128);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 6000) - 3000);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] v [LANES];
        foreach (v[i]) v[i] = 16'h7fff;
        send_group(v, 8, 1);
        foreach (v[i]) v[i] = 16'h8000;
        send_group(v, 8, 1);
        // empty vector, plain and with earlier empty groups
        send_group(v, 0, 1);
        send_group(v, 0, 0);
        send_group(v, 0, 1);
        // count above lanes saturates
        foreach (v[i]) v[i] = 16'(i * 300);
        send_group(v, 15, 1);
        send_group(v, 9, 0);
        send_group(v, 3, 1);
        // rising then falling maximum, partial lanes
        foreach (v[i]) v[i] = 16'h8000;
        send_group(v, 8, 0);
        foreach (v[i]) v[i] = 16'h7fff;
        send_group(v, 5, 0);
        foreach (v[i]) v[i] = 16'h0000;
        send_group(v, 8, 1);
        // alternating-bit patterns mixed with all-ones
        foreach (v[i]) v[i] = i[0] ? 16'hffff : 16'h5555;
        send_group(v, 8, 0);
        foreach (v[i]) v[i] = 16'haaaa;
        send_group(v, 7, 1);
    endtask

    // equal values add one unit to each lane sum per group
    task automatic test_saturation();
        logic [15:0] v [LANES];
        foreach (v[i]) v[i] = 16'h0400;
        for (int n = 0; n < 3; n++) send_group(v, 8, n == 2);
    endtask

    task automatic test_random(int groups);
        logic [15:0] v [LANES];
        int mode, len;
        int sent;
        sent = 0;
        while (sent < groups) begin
            len = $urandom_range(1, 6);
            mode = $urandom_range(3);
            for (int g = 0; g < len; g++) begin
                foreach (v[i]) v[i] = rand_sample($urandom_range(9) == 0 ? 2 : mode);
                send_group(v, ($urandom_range(9) == 0) ? $urandom_range(15)
                                                       : $urandom_range(1, 8),
                           g == len - 1);
                sent++;
            end
        end
    endtask

    // receiver held off so results back up into the input
    task automatic test_backpressure();
        hold_rx = 1;
        idle_pct = 0;
        test_random(30);
        hold_rx = 0;
        idle_pct = 32;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result lse=%0h", m_tdata);
                fails++;
            end else begin
                exp_r = pending_q.pop_front();
                if (m_tdata !== exp_r.lse) begin
                    $error("log_sum_exp exp %0h got %0h", exp_r.lse, m_tdata);
                    fails++;
                end
                if (m_tuser[0] !== exp_r.empty) begin
                    $error("empty_vector exp %0b got %0b", exp_r.empty, m_tuser[0]);
                    fails++;
                end
                if (m_tuser[1] !== exp_r.sat) begin
                    $error("sum_saturated exp %0b got %0b", exp_r.sat, m_tuser[1]);
                    fails++;
                end
            end
        end
    end

    // receiver readiness, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_rx) begin
            m_tready <= 0;
            repeat (3000) @(posedge i_clk);
            m_tready <= 1;
            wait (!hold_rx);
        end else begin
            m_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clear_lanes();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_random(200);
        test_backpressure();
        idle_pct = 0;
        test_random(80);
        idle_pct = 32;
        test_random(200);
        s_tvalid <= 0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/olse_pkg.sv
rtl/olse_exp.sv
rtl/olse_dp.sv
rtl/olse_ctrl.sv
rtl/online_logsumexp_reduce_top.sv
tb/sv/online_logsumexp_reduce_top_tb.sv
